[rtl/core/vrs_pkg.sv]
package vrs_pkg;

    // Command codes carried by the command field.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // Width of the record data and read data words, in bytes.
    localparam int DATA_BYTES = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the incoming transaction
        logic wr_step;      // write one byte and advance the byte counter
        logic push_commit;  // move the top past the record and its trailer
        logic rd_step;      // issue one byte read and advance the byte counter
        logic rd_sel_rec;   // read address from the record start, not the trailer
        logic calc;         // decode the trailer into start and copy count
        logic pop_commit;   // move the top down to the record start
        logic clear_top;    // empty the stack
        logic out_load;     // load the result register
        logic out_ok;       // success flag to load with the result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic fits;
        logic has_trailer;
        logic top_nonzero;
        logic wr_last;
        logic trl_last;
        logic rec_last;
        logic calc_zero;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/core/vrs_ctrl.sv]
module vrs_ctrl
    import vrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WRITE,
        ST_TRL_RD,
        ST_TRL_WAIT,
        ST_CALC,
        ST_REC_RD,
        ST_REC_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ok_reg;
    logic   ok_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        cmd.out_ok = ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                case (sts.op)
                    OP_PUSH:
                    begin
                        if (sts.fits)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_FINISH;
                        end
                    end
                    OP_POP, OP_PEEK:
                    begin
                        if (sts.has_trailer)
                        begin
                            state_next = ST_TRL_RD;
                        end
                        else
                        begin
                            // A pop of a stack too short for a trailer empties it.
                            if (sts.op == OP_POP && sts.top_nonzero)
                            begin
                                cmd.clear_top = 1'b1;
                            end
                            ok_next    = 1'b0;
                            state_next = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        cmd.clear_top = 1'b1;
                        ok_next       = 1'b1;
                        state_next    = ST_FINISH;
                    end
                endcase
            end
            ST_WRITE:
            begin
                cmd.wr_step = 1'b1;
                if (sts.wr_last)
                begin
                    cmd.push_commit = 1'b1;
                    ok_next         = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_TRL_RD:
            begin
                cmd.rd_step = 1'b1;
                if (sts.trl_last)
                begin
                    state_next = ST_TRL_WAIT;
                end
            end
            ST_TRL_WAIT:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc = 1'b1;
                if (sts.calc_zero)
                begin
                    state_next = ST_REC_WAIT;
                end
                else
                begin
                    state_next = ST_REC_RD;
                end
            end
            ST_REC_RD:
            begin
                cmd.rd_step    = 1'b1;
                cmd.rd_sel_rec = 1'b1;
                if (sts.rec_last)
                begin
                    state_next = ST_REC_WAIT;
                end
            end
            ST_REC_WAIT:
            begin
                if (sts.op == OP_POP)
                begin
                    cmd.pop_commit = 1'b1;
                end
                ok_next    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

    // A new transaction is never taken twice in a row.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("transaction accepted while the previous one was in progress");

    // The result register is only loaded when it is free.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten before it was taken");

    // At most one update of the top pointer per cycle.
    a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push_commit, cmd.pop_commit, cmd.clear_top}))
        else $error("conflicting top pointer updates");

endmodule

[rtl/core/vrs_datapath.sv]
module vrs_datapath
    import vrs_pkg::*;
#(
    parameter int STACK_BYTES = 1024,
    parameter int MAX_RECORD  = 8,
    parameter int LEN_BYTES   = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              command,
    input  logic [8*DATA_BYTES-1:0] element_data,
    input  logic [3:0]              length,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic                    ok,
    output logic [8*DATA_BYTES-1:0] read_data,
    output logic [3:0]              bytes_copied,
    output logic                    is_empty,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              sts
);

    localparam int AW = $clog2(STACK_BYTES);
    localparam int PW = $clog2(STACK_BYTES + 1);
    localparam int SW = PW + 2;
    localparam int TW = 8 * LEN_BYTES;
    localparam int CW = (TW > PW) ? TW : PW;

    logic [7:0]              mem_reg [STACK_BYTES];
    logic [7:0]              rdata_reg;

    logic [PW-1:0]           top_reg,      top_next;
    logic [3:0]              cnt_reg,      cnt_next;
    op_t                     op_reg,       op_next;
    logic [8*DATA_BYTES-1:0] data_reg,     data_next;
    logic [3:0]              len_reg,      len_next;
    logic [TW-1:0]           trl_reg,      trl_next;
    logic [8*DATA_BYTES-1:0] acc_reg,      acc_next;
    logic [PW-1:0]           start_reg,    start_next;
    logic [3:0]              copied_reg,   copied_next;
    logic                    rd_pend_reg,  rd_pend_next;
    logic [2:0]              rd_idx_reg,   rd_idx_next;
    logic                    rd_trl_reg,   rd_trl_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_ok_reg,   out_ok_next;
    logic [8*DATA_BYTES-1:0] out_data_reg, out_data_next;
    logic [3:0]              out_cnt_reg,  out_cnt_next;
    logic                    out_empty_reg, out_empty_next;

    logic [PW-1:0]           below;
    logic [PW-1:0]           stored_cl;
    logic [PW-1:0]           calc_start;
    logic [3:0]              stored4;
    logic [3:0]              min4;
    logic [3:0]              calc_copied;
    logic [PW-1:0]           wr_addr;
    logic [PW-1:0]           rd_addr;
    logic [7:0]              wr_byte;
    logic [4:0]              wr_last_idx;

    // Trailer decode: the stored length is clamped to the bytes below it.
    assign below      = top_reg - PW'(LEN_BYTES);
    assign stored_cl  = (CW'(trl_reg) > CW'(below)) ? below : PW'(trl_reg);
    assign calc_start = below - stored_cl;
    assign stored4    = (stored_cl > PW'(15)) ? 4'd15 : stored_cl[3:0];
    assign min4       = (len_reg < stored4) ? len_reg : stored4;
    assign calc_copied = (min4 > 4'(DATA_BYTES)) ? 4'(DATA_BYTES) : min4;

    assign wr_addr     = top_reg + PW'(cnt_reg);
    assign rd_addr     = cmd.rd_sel_rec ? (start_reg + PW'(cnt_reg)) : (below + PW'(cnt_reg));
    assign wr_last_idx = {1'b0, len_reg} + 5'(LEN_BYTES) - 5'd1;

    // Record bytes first, then the trailer whose low byte is the length.
    always_comb
    begin
        if (cnt_reg < len_reg)
        begin
            wr_byte = data_reg[7:0];
        end
        else if (cnt_reg == len_reg)
        begin
            wr_byte = 8'(len_reg);
        end
        else
        begin
            wr_byte = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_step)
        begin
            mem_reg[wr_addr[AW-1:0]] <= wr_byte;
        end
        if (cmd.rd_step)
        begin
            rdata_reg <= mem_reg[rd_addr[AW-1:0]];
        end
    end

    always_comb
    begin
        top_next       = top_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        len_next       = len_reg;
        trl_next       = trl_reg;
        acc_next       = acc_reg;
        start_next     = start_reg;
        copied_next    = copied_reg;
        rd_pend_next   = cmd.rd_step;
        rd_idx_next    = cnt_reg[2:0];
        rd_trl_next    = !cmd.rd_sel_rec;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_data_next  = out_data_reg;
        out_cnt_next   = out_cnt_reg;
        out_empty_next = out_empty_reg;

        if (cmd.load)
        begin
            op_next     = op_t'(command);
            data_next   = element_data;
            len_next    = length;
            cnt_next    = 4'd0;
            acc_next    = '0;
            copied_next = 4'd0;
        end

        if (cmd.wr_step)
        begin
            cnt_next  = cnt_reg + 4'd1;
            data_next = {8'd0, data_reg[8*DATA_BYTES-1:8]};
        end

        if (cmd.rd_step)
        begin
            cnt_next = cnt_reg + 4'd1;
        end

        // The byte read in the previous cycle lands in its lane.
        if (rd_pend_reg)
        begin
            if (rd_trl_reg)
            begin
                for (int j = 0; j < LEN_BYTES; j++)
                begin
                    if (rd_idx_reg == 3'(j))
                    begin
                        trl_next[8*j +: 8] = rdata_reg;
                    end
                end
            end
            else
            begin
                acc_next[8*rd_idx_reg +: 8] = rdata_reg;
            end
        end

        if (cmd.calc)
        begin
            start_next  = calc_start;
            copied_next = calc_copied;
            cnt_next    = 4'd0;
        end

        if (cmd.push_commit)
        begin
            top_next = top_reg + PW'(len_reg) + PW'(LEN_BYTES);
        end
        if (cmd.pop_commit)
        begin
            top_next = start_reg;
        end
        if (cmd.clear_top)
        begin
            top_next = '0;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = cmd.out_ok;
            out_data_next  = acc_reg;
            out_cnt_next   = copied_reg;
            out_empty_next = (top_reg == '0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            cnt_reg       <= 4'd0;
            rd_pend_reg   <= 1'b0;
            rd_trl_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_trl_reg    <= rd_trl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        data_reg      <= data_next;
        len_reg       <= len_next;
        trl_reg       <= trl_next;
        acc_reg       <= acc_next;
        start_reg     <= start_next;
        copied_reg    <= copied_next;
        rd_idx_reg    <= rd_idx_next;
        out_ok_reg    <= out_ok_next;
        out_data_reg  <= out_data_next;
        out_cnt_reg   <= out_cnt_next;
        out_empty_reg <= out_empty_next;
    end

    assign sts.op          = op_reg;
    assign sts.fits        = (len_reg <= 4'(MAX_RECORD)) &&
                             (SW'(top_reg) + SW'(len_reg) + SW'(LEN_BYTES) <= SW'(STACK_BYTES));
    assign sts.has_trailer = (top_reg >= PW'(LEN_BYTES));
    assign sts.top_nonzero = (top_reg != '0);
    assign sts.wr_last     = ({1'b0, cnt_reg} == wr_last_idx);
    assign sts.trl_last    = (cnt_reg == 4'(LEN_BYTES - 1));
    assign sts.rec_last    = (cnt_reg == copied_reg - 4'd1);
    assign sts.calc_zero   = (calc_copied == 4'd0);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign read_data    = out_data_reg;
    assign bytes_copied = out_cnt_reg;
    assign is_empty     = out_empty_reg;

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_step && cmd.rd_step))
        else $error("memory written and read in the same cycle");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= PW'(STACK_BYTES))
        else $error("top pointer beyond capacity");

    a_capture_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_step |=> rd_pend_reg)
        else $error("read byte not captured");

endmodule

[rtl/core/variable_record_stack_core.sv]
// Channel   Handshake              Payload
// input     in_valid / in_ready    command, element_data, length
// output    out_valid / out_ready  ok, read_data, bytes_copied, is_empty
//
// Sequence: a push writes its record bytes and then its trailer; a pop or peek reads the
// trailer, decodes it and then reads the record bytes; a refused push, a failed pop or
// peek, or a clear goes straight to the result. The single byte-wide stack memory moves
// one byte a cycle, and its read data is registered.
// Reset: asynchronous and active low; it empties the stack and drops any pending result.
// The stack memory itself is not cleared: only bytes below the top are ever read.
// Stalls: a finished result waits in the output register, and the next transaction is
// accepted and worked on meanwhile; it stalls only when its own result is ready.
module variable_record_stack_core
    import vrs_pkg::*;
#(
    parameter int STACK_BYTES = 1024,
    parameter int MAX_RECORD  = 8,
    parameter int LEN_BYTES   = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  logic [8*DATA_BYTES-1:0] element_data,
    input  logic [3:0]              length,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    ok,
    output logic [8*DATA_BYTES-1:0] read_data,
    output logic [3:0]              bytes_copied,
    output logic                    is_empty
);

    // The controller sequences each transaction; the datapath owns the stack memory,
    // the top pointer, the byte counter and the result register.
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    vrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vrs_datapath #(
        .STACK_BYTES (STACK_BYTES),
        .MAX_RECORD  (MAX_RECORD),
        .LEN_BYTES   (LEN_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .element_data (element_data),
        .length       (length),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .ok           (ok),
        .read_data    (read_data),
        .bytes_copied (bytes_copied),
        .is_empty     (is_empty),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
